// File: hdl/wlmv_pkg.sv
package wlmv_pkg;

    localparam int LABEL_W = 16;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LABEL  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ALLOC,
        S_VOTE_START,
        S_VRD,
        S_VCMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               in_bounds;
        logic               last_in_window;
    } t_in_req;

    typedef struct packed {
        logic [LABEL_W-1:0] mode_label;
        logic [COUNT_W-1:0] mode_count;
        logic               write_enable;
    } t_out_req;

endpackage

// File: hdl/window_label_mode_vote.sv
// Sequence: a request is accepted in S_IDLE; table entries are read (S_RD) and compared
//   (S_CMP) until a hit or the last used entry, and a new label is written in S_ALLOC.
//   Window close: S_VRD and S_VCMP per used entry, then S_EMIT loads the result register.
// The result load also waits while a stalled response still holds the result register.
// Throughput: one request at a time; the single table memory port and one comparator set it.
// Reset (sync, active low) clears the sequencer, fill count, result valid and config regs.
module window_label_mode_vote #(
    parameter int MAX_DISTINCT = 64,
    parameter int LABEL_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_req_valid,
    output logic                                    o_req_stall,
    input  wlmv_pkg::t_in_req                       i_req,
    output logic                                    o_rsp_valid,
    input  logic                                    i_rsp_stall,
    output wlmv_pkg::t_out_req                      o_rsp,
    input  logic                                    i_cfg_wr_en,
    input  logic [wlmv_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wlmv_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import wlmv_pkg::*;

    // Table geometry: IDX_W addresses an entry, CNT_W holds 0..MAX_DISTINCT.
    localparam int IDX_W   = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int CNT_W   = $clog2(MAX_DISTINCT + 1);
    // Stored label width: labels are masked to LABEL_BITS, never wider than the field.
    localparam int STORE_W = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DISTINCT);

    // Table memories: one port, registered read. Only entries below r_used are read,
    // so the fill count stands in for any clearing.
    logic [STORE_W-1:0] m_label [MAX_DISTINCT];
    logic [CNT_W-1:0]   m_count [MAX_DISTINCT];

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [STORE_W-1:0] r_label;
    logic               r_last;
    logic [STORE_W-1:0] r_rd_label;
    logic [CNT_W-1:0]   r_rd_count;
    logic [STORE_W-1:0] r_best_label, n_best_label;
    logic [CNT_W-1:0]   r_best_count, n_best_count;
    t_out_req           r_out;
    logic               r_out_valid;
    logic               r_sel_en;
    logic [LABEL_W-1:0] r_sel_label;

    // memory controls
    logic               rd_en;
    logic               wr_label_en;
    logic               wr_count_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [CNT_W-1:0]   wr_count;
    logic               load_out;

    logic               req_take;
    logic               at_end;      // r_idx is the last used entry
    logic               hit;
    logic               out_free;
    logic [LABEL_W-1:0] best_ext;

    assign req_take = i_req_valid && (r_state == S_IDLE);
    assign at_end   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_used);
    assign hit      = (r_rd_label == r_label);
    assign out_free = !r_out_valid || !i_rsp_stall;
    assign best_ext = LABEL_W'(r_best_label);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.in_bounds) begin
                        n_state = (r_used == '0) ? S_ALLOC : S_RD;
                    end else if (i_req.last_in_window) begin
                        n_state = S_VOTE_START;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_state = r_last ? S_VOTE_START : S_IDLE;
                end else if (at_end) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ALLOC: begin
                n_state = r_last ? S_VOTE_START : S_IDLE;
            end
            S_VOTE_START: begin
                n_state = (r_used == '0) ? S_EMIT : S_VRD;
            end
            S_VRD: begin
                n_state = S_VCMP;
            end
            S_VCMP: begin
                n_state = at_end ? S_EMIT : S_VRD;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath controls ----------------
    always_comb begin
        n_idx        = r_idx;
        n_used       = r_used;
        n_best_label = r_best_label;
        n_best_count = r_best_count;
        rd_en        = 1'b0;
        wr_label_en  = 1'b0;
        wr_count_en  = 1'b0;
        wr_addr      = r_idx;
        wr_count     = r_rd_count;
        load_out     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
            end
            S_RD: begin
                rd_en = 1'b1;
            end
            S_CMP: begin
                if (hit) begin
                    // saturating increment of the matching entry
                    wr_count_en = 1'b1;
                    if (r_rd_count < MAX_CNT) begin
                        wr_count = r_rd_count + CNT_W'(1);
                    end
                end else if (!at_end) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_ALLOC: begin
                // new label goes to the next free entry; dropped when the table is full
                if (r_used < MAX_CNT) begin
                    wr_addr     = r_used[IDX_W-1:0];
                    wr_label_en = 1'b1;
                    wr_count_en = 1'b1;
                    wr_count    = CNT_W'(1);
                    n_used      = r_used + CNT_W'(1);
                end
            end
            S_VOTE_START: begin
                n_idx        = '0;
                n_best_label = '0;
                n_best_count = '0;
            end
            S_VRD: begin
                rd_en = 1'b1;
            end
            S_VCMP: begin
                // strict compare keeps the earliest entry on a tie
                if (r_rd_count > r_best_count) begin
                    n_best_label = r_rd_label;
                    n_best_count = r_rd_count;
                end
                if (!at_end) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_used   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // ---------------- table memories ----------------
    always_ff @(posedge i_clk) begin
        if (wr_label_en) begin
            m_label[wr_addr] <= r_label;
        end
        if (wr_count_en) begin
            m_count[wr_addr] <= wr_count;
        end
        if (rd_en) begin
            r_rd_label <= m_label[r_idx];
            r_rd_count <= m_count[r_idx];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_sel_en    <= 1'b0;
            r_sel_label <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SELECT_ENABLE: r_sel_en    <= i_cfg_data[0];
                    CFG_SELECT_LABEL:  r_sel_label <= i_cfg_data[LABEL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_best_label <= n_best_label;
        r_best_count <= n_best_count;
        if (req_take) begin
            r_label <= i_req.label[STORE_W-1:0];
            r_last  <= i_req.last_in_window;
        end
        if (load_out) begin
            r_out.mode_label   <= best_ext;
            r_out.mode_count   <= COUNT_W'(r_best_count);
            r_out.write_enable <= !r_sel_en || (best_ext == r_sel_label);
        end
    end

endmodule
